FILE: src/agb_pkg.sv
// ----------------------------------------------------------------------------
// agb_pkg: shared types and helpers for the antialiased glyph blender
// Payload structs, register indexes, state encoding and pixel unpacking.
// ----------------------------------------------------------------------------
package agb_pkg;

  localparam int DEF_MAX_GLYPH_WIDTH  = 64;
  localparam int DEF_MAX_GLYPH_HEIGHT = 64;

  localparam int COLOR_W     = 24;
  localparam int LEVEL_W     = 8;
  localparam int LOG2_W      = 2;
  localparam int DIM_W       = 7;
  localparam int ORIGIN_W    = 12;
  localparam int COORD_W     = 13;
  localparam int SLOTS       = 8;
  localparam int SLOT_W      = 3;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 24;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_FONT_COLOR      = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PIXEL_BITS_LOG2 = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_GLYPH_WIDTH     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_GLYPH_HEIGHT    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_BYTES_PER_LINE  = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_X        = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_Y        = 3'd6;

  typedef struct packed {
    logic [7:0]         glyph_byte;
    logic [COLOR_W-1:0] background_0;
    logic [COLOR_W-1:0] background_1;
    logic [COLOR_W-1:0] background_2;
    logic [COLOR_W-1:0] background_3;
  } in_item_t;

  typedef struct packed {
    logic [COORD_W-1:0] screen_x;
    logic [COORD_W-1:0] screen_y;
    logic [COLOR_W-1:0] pixel_color;
    logic               last_of_byte;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SCAN,
    ST_BLEND,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic               start;
    logic [LOG2_W-1:0]  pixel_bits_log2;
    logic [LEVEL_W-1:0] level;
    logic [COLOR_W-1:0] fg;
    logic [COLOR_W-1:0] bg;
  } blend_req_t;

  typedef struct packed {
    logic               done;
    logic [COLOR_W-1:0] color;
  } blend_resp_t;

  // full level for a pixel depth: 2^bits - 1
  function automatic logic [LEVEL_W-1:0] level_max(input logic [LOG2_W-1:0] lg);
    case (lg)
      2'd0:    return 8'h01;
      2'd1:    return 8'h03;
      2'd2:    return 8'h0F;
      default: return 8'hFF;
    endcase
  endfunction

  // level of a pixel slot, leftmost slot in the top bits
  function automatic logic [LEVEL_W-1:0] slot_level(input logic [7:0]        data,
                                                    input logic [LOG2_W-1:0] lg,
                                                    input logic [SLOT_W-1:0] s);
    logic [7:0] sh;
    case (lg)
      2'd0: begin
        sh = data << s;
        return {7'd0, sh[7]};
      end
      2'd1: begin
        sh = data << {s[1:0], 1'b0};
        return {6'd0, sh[7:6]};
      end
      2'd2: begin
        sh = data << {s[0], 2'b00};
        return {4'd0, sh[7:4]};
      end
      default: begin
        sh = data;
        return sh;
      end
    endcase
  endfunction

endpackage

FILE: src/antialiased_glyph_blender.sv
// ----------------------------------------------------------------------------
// antialiased_glyph_blender: glyph bitmap to blended screen pixels
// Unpacks one bitmap byte at a time, drops empty and out-of-width pixels and
// emits a coordinate and color per visible pixel, blending partial levels.
// ----------------------------------------------------------------------------
// sequence: the request is accepted, the pixel mask is built, then each
//   visible pixel is picked, blended when at a partial level, and emitted
// a new byte is taken only once the last pixel of the current one is emitted;
//   the partial-level cost is the shared multiplier, 6 terms x 3 phases
// reset: synchronous, clears the counters, handshakes and sequencer and loads
//   the register defaults (white font, 1 bit per pixel, 8x8 glyph, 1 byte/row)
// ----------------------------------------------------------------------------
module antialiased_glyph_blender #(
  parameter int MAX_GLYPH_WIDTH  = agb_pkg::DEF_MAX_GLYPH_WIDTH,
  parameter int MAX_GLYPH_HEIGHT = agb_pkg::DEF_MAX_GLYPH_HEIGHT
) (
  input  logic                            clk,
  input  logic                            rst,
  // configuration write port
  input  logic                            cfg_write,
  input  logic [agb_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [agb_pkg::CFG_DATA_W-1:0]  cfg_data,
  // bitmap byte requests
  input  logic                            in_valid,
  output logic                            in_stall,
  input  agb_pkg::in_item_t               in_data,
  // pixel requests
  output logic                            out_valid,
  input  logic                            out_stall,
  output agb_pkg::out_item_t              out_data
);

  // counter widths follow the glyph size limits
  localparam int BW     = $clog2(MAX_GLYPH_WIDTH);
  localparam int RW     = $clog2(MAX_GLYPH_HEIGHT);
  localparam int CW     = (BW + 1 > agb_pkg::DIM_W) ? BW + 1 : agb_pkg::DIM_W;
  localparam int HW     = (RW + 1 > agb_pkg::DIM_W) ? RW + 1 : agb_pkg::DIM_W;
  localparam int COL_W  = BW + 3;
  localparam int SLOTS  = agb_pkg::SLOTS;
  localparam int SLOT_W = agb_pkg::SLOT_W;

  // configuration registers
  logic [agb_pkg::COLOR_W-1:0]  font_color;
  logic [agb_pkg::LOG2_W-1:0]   pixel_bits_log2;
  logic [agb_pkg::DIM_W-1:0]    glyph_width;
  logic [agb_pkg::DIM_W-1:0]    glyph_height;
  logic [agb_pkg::DIM_W-1:0]    bytes_per_line;
  logic [agb_pkg::ORIGIN_W-1:0] origin_x;
  logic [agb_pkg::ORIGIN_W-1:0] origin_y;

  // glyph position
  logic [BW-1:0]                byte_in_row;
  logic [RW-1:0]                row_index;

  // sequencer and per-byte hold registers
  agb_pkg::state_t              state;
  agb_pkg::state_t              state_next;
  agb_pkg::in_item_t            item_hold;
  logic [COL_W-1:0]             base_col;
  logic [agb_pkg::COORD_W-1:0]  pos_y;
  logic [SLOTS-1:0]             mask;
  logic [SLOTS-1:0]             mask_next;
  logic [SLOT_W-1:0]            slot;
  logic [agb_pkg::COLOR_W-1:0]  color_hold;

  // control decoded from the state
  logic                         accept;
  logic                         do_load;
  logic                         do_pick;
  logic                         pick_full;
  logic                         do_emit;
  logic                         out_free;

  // limits and per-slot decode
  logic [CW-1:0]                bpl_lim;
  logic [CW-1:0]                wid_lim;
  logic [HW-1:0]                hgt_lim;
  logic [CW-1:0]                bir_inc;
  logic [HW-1:0]                row_inc;
  logic [COL_W-1:0]             wid_col;
  logic [3:0]                   per_byte;
  logic [agb_pkg::LEVEL_W-1:0]  maxl;
  logic [SLOT_W-1:0]            first_slot;
  logic [agb_pkg::LEVEL_W-1:0]  first_level;
  logic [SLOTS-1:0]             mask_rest;
  logic [COL_W-1:0]             col_cur;
  logic [agb_pkg::COLOR_W-1:0]  bg_first;

  agb_pkg::blend_req_t          blend_req;
  agb_pkg::blend_resp_t         blend_resp;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (rst) begin
      font_color      <= 24'hFFFFFF;
      pixel_bits_log2 <= '0;
      glyph_width     <= agb_pkg::DIM_W'(8);
      glyph_height    <= agb_pkg::DIM_W'(8);
      bytes_per_line  <= agb_pkg::DIM_W'(1);
      origin_x        <= '0;
      origin_y        <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        agb_pkg::REG_FONT_COLOR:      font_color      <= cfg_data;
        agb_pkg::REG_PIXEL_BITS_LOG2: pixel_bits_log2 <= cfg_data[agb_pkg::LOG2_W-1:0];
        agb_pkg::REG_GLYPH_WIDTH:     glyph_width     <= cfg_data[agb_pkg::DIM_W-1:0];
        agb_pkg::REG_GLYPH_HEIGHT:    glyph_height    <= cfg_data[agb_pkg::DIM_W-1:0];
        agb_pkg::REG_BYTES_PER_LINE:  bytes_per_line  <= cfg_data[agb_pkg::DIM_W-1:0];
        agb_pkg::REG_ORIGIN_X:        origin_x        <= cfg_data[agb_pkg::ORIGIN_W-1:0];
        agb_pkg::REG_ORIGIN_Y:        origin_y        <= cfg_data[agb_pkg::ORIGIN_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- limits
  // bytes per line and height saturate into 1..max, width only from above
  always_comb begin
    if (bytes_per_line == '0) begin
      bpl_lim = CW'(1);
    end else if (CW'(bytes_per_line) > CW'(MAX_GLYPH_WIDTH)) begin
      bpl_lim = CW'(MAX_GLYPH_WIDTH);
    end else begin
      bpl_lim = CW'(bytes_per_line);
    end

    if (CW'(glyph_width) > CW'(MAX_GLYPH_WIDTH)) begin
      wid_lim = CW'(MAX_GLYPH_WIDTH);
    end else begin
      wid_lim = CW'(glyph_width);
    end

    if (glyph_height == '0) begin
      hgt_lim = HW'(1);
    end else if (HW'(glyph_height) > HW'(MAX_GLYPH_HEIGHT)) begin
      hgt_lim = HW'(MAX_GLYPH_HEIGHT);
    end else begin
      hgt_lim = HW'(glyph_height);
    end
  end

  assign bir_inc  = CW'(byte_in_row) + CW'(1);
  assign row_inc  = HW'(row_index) + HW'(1);
  assign wid_col  = COL_W'(wid_lim);
  assign per_byte = 4'd8 >> pixel_bits_log2;
  assign maxl     = agb_pkg::level_max(pixel_bits_log2);

  // ---------------------------------------------------------------- slot decode
  // visible slots: inside the byte, nonzero level, left of the glyph width
  always_comb begin
    for (int s = 0; s < SLOTS; s++) begin
      mask_next[s] = (4'(s) < per_byte) &&
                     (agb_pkg::slot_level(item_hold.glyph_byte, pixel_bits_log2,
                                          SLOT_W'(s)) != '0) &&
                     ((base_col + COL_W'(s)) < wid_col);
    end
  end

  // leftmost remaining visible slot
  always_comb begin
    first_slot = '0;
    for (int s = SLOTS - 1; s >= 0; s--) begin
      if (mask[s]) begin
        first_slot = SLOT_W'(s);
      end
    end
  end

  assign first_level = agb_pkg::slot_level(item_hold.glyph_byte, pixel_bits_log2,
                                           first_slot);
  assign mask_rest   = mask & ~(SLOTS'(1) << slot);
  assign col_cur     = base_col + COL_W'(slot);

  // background for the slot being picked
  always_comb begin
    case (first_slot[1:0])
      2'd0:    bg_first = item_hold.background_0;
      2'd1:    bg_first = item_hold.background_1;
      2'd2:    bg_first = item_hold.background_2;
      default: bg_first = item_hold.background_3;
    endcase
  end

  // ---------------------------------------------------------------- sequencer
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    case (state)
      agb_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = agb_pkg::ST_LOAD;
        end
      end
      agb_pkg::ST_LOAD: begin
        state_next = agb_pkg::ST_SCAN;
      end
      agb_pkg::ST_SCAN: begin
        if (mask == '0) begin
          state_next = agb_pkg::ST_IDLE;
        end else if (first_level == maxl) begin
          state_next = agb_pkg::ST_EMIT;
        end else begin
          state_next = agb_pkg::ST_BLEND;
        end
      end
      agb_pkg::ST_BLEND: begin
        if (blend_resp.done) begin
          state_next = agb_pkg::ST_EMIT;
        end
      end
      agb_pkg::ST_EMIT: begin
        if (out_free) begin
          state_next = (mask_rest == '0) ? agb_pkg::ST_IDLE : agb_pkg::ST_SCAN;
        end
      end
      default: begin
        state_next = agb_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall  = (state != agb_pkg::ST_IDLE);
    accept    = in_valid && (state == agb_pkg::ST_IDLE);
    do_load   = (state == agb_pkg::ST_LOAD);
    do_pick   = (state == agb_pkg::ST_SCAN) && (mask != '0);
    pick_full = (first_level == maxl);
    do_emit   = (state == agb_pkg::ST_EMIT) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= agb_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // ---------------------------------------------------------------- glyph position
  // counters advance as the byte is taken; a smaller new limit wraps them
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_in_row <= '0;
      row_index   <= '0;
    end else if (accept) begin
      if (bir_inc >= bpl_lim) begin
        byte_in_row <= '0;
        if (row_inc >= hgt_lim) begin
          row_index <= '0;
        end else begin
          row_index <= row_inc[RW-1:0];
        end
      end else begin
        byte_in_row <= bir_inc[BW-1:0];
      end
    end
  end

  // ---------------------------------------------------------------- byte hold
  always_ff @(posedge clk) begin
    if (accept) begin
      item_hold <= in_data;
      base_col  <= COL_W'(byte_in_row) << (2'd3 - pixel_bits_log2);
      pos_y     <= agb_pkg::COORD_W'(origin_y) + agb_pkg::COORD_W'(row_index);
    end
    if (do_pick) begin
      slot <= first_slot;
      if (pick_full) begin
        color_hold <= font_color;
      end
    end
    if ((state == agb_pkg::ST_BLEND) && blend_resp.done) begin
      color_hold <= blend_resp.color;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= '0;
    end else if (do_load) begin
      mask <= mask_next;
    end else if (do_emit) begin
      mask <= mask_rest;
    end
  end

  // ---------------------------------------------------------------- blend unit
  always_comb begin
    blend_req.start           = do_pick && !pick_full;
    blend_req.pixel_bits_log2 = pixel_bits_log2;
    blend_req.level           = first_level;
    blend_req.fg              = font_color;
    blend_req.bg              = bg_first;
  end

  agb_blend u_blend (
    .clk  (clk),
    .rst  (rst),
    .req  (blend_req),
    .resp (blend_resp)
  );

  // ---------------------------------------------------------------- output register
  // parts the sequencer from the sink so the next byte can be taken meanwhile
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (do_emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_emit) begin
      out_data.screen_x     <= agb_pkg::COORD_W'(origin_x) + agb_pkg::COORD_W'(col_cur);
      out_data.screen_y     <= pos_y;
      out_data.pixel_color  <= color_hold;
      out_data.last_of_byte <= (mask_rest == '0);
    end
  end

  // ---------------------------------------------------------------- checks
  // the blend unit only reports back while the sequencer waits for it
  a_blend_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    blend_resp.done |-> (state == agb_pkg::ST_BLEND))
    else $error("blend result arrived outside the blend wait");

  // no visible slot beyond the pixels packed in one byte
  a_mask_in_byte: assert property (@(posedge clk) disable iff (rst)
    (state == agb_pkg::ST_SCAN) |-> ((mask >> per_byte) == '0))
    else $error("pixel mask has slots beyond the byte");

  // after a byte is taken the column counter is inside the line
  a_byte_in_line: assert property (@(posedge clk) disable iff (rst)
    accept |=> (CW'(byte_in_row) < $past(bpl_lim)))
    else $error("byte counter past the line length");

  // an emitted pixel always clears its slot from the mask
  a_emit_clears: assert property (@(posedge clk) disable iff (rst)
    do_emit |=> (mask == $past(mask_rest)))
    else $error("emitted slot still pending");

endmodule

FILE: src/agb_blend.sv
// ----------------------------------------------------------------------------
// agb_blend: iterative per-channel alpha blend
// One shared multiplier walks six terms (font and background for each of the
// three channels); each term is a product, a reciprocal multiply and a
// one-step remainder fix-up that gives the truncated quotient by the max level.
// ----------------------------------------------------------------------------
module agb_blend (
  input  logic                clk,
  input  logic                rst,
  input  agb_pkg::blend_req_t req,
  output agb_pkg::blend_resp_t resp
);

  localparam logic [1:0] PH_PROD  = 2'd0;
  localparam logic [1:0] PH_RECIP = 2'd1;
  localparam logic [1:0] PH_FIX   = 2'd2;
  localparam logic [2:0] LAST_TERM = 3'd5;

  // floor(2^24 / max level), saturated to 24 bits for a max level of 1
  function automatic logic [23:0] recip(input logic [agb_pkg::LOG2_W-1:0] lg);
    case (lg)
      2'd0:    return 24'hFFFFFF;
      2'd1:    return 24'h555555;
      2'd2:    return 24'h111111;
      default: return 24'h010101;
    endcase
  endfunction

  logic                              busy;
  logic                              done;
  logic [2:0]                        term;
  logic [1:0]                        phase;
  logic [agb_pkg::LOG2_W-1:0]        lg;
  logic [agb_pkg::LEVEL_W-1:0]       lvl;
  logic [agb_pkg::COLOR_W-1:0]       fg;
  logic [agb_pkg::COLOR_W-1:0]       bg;
  logic [2:0][7:0]                   acc;
  logic [15:0]                       x;
  logic [39:0]                       prod_r;

  logic [39:0]                       prod;
  logic [15:0]                       mul_a;
  logic [23:0]                       mul_b;
  logic [7:0]                        maxl;
  logic [7:0]                        inv;
  logic [7:0]                        fg_ch;
  logic [7:0]                        bg_ch;
  logic [7:0]                        opnd;
  logic [7:0]                        weight;
  logic [3:0]                        bits;
  logic [7:0]                        q0;
  logic [7:0]                        q;
  logic [17:0]                       qd;
  logic [17:0]                       r0;

  assign maxl = agb_pkg::level_max(lg);
  assign inv  = maxl - lvl;
  assign bits = 4'd1 << lg;

  always_comb begin
    case (term[2:1])
      2'd0: begin
        fg_ch = fg[23:16];
        bg_ch = bg[23:16];
      end
      2'd1: begin
        fg_ch = fg[15:8];
        bg_ch = bg[15:8];
      end
      default: begin
        fg_ch = fg[7:0];
        bg_ch = bg[7:0];
      end
    endcase
  end

  assign opnd   = term[0] ? bg_ch : fg_ch;
  assign weight = term[0] ? inv : lvl;

  // shared multiplier
  assign mul_a = (phase == PH_PROD) ? {8'd0, opnd} : prod_r[15:0];
  assign mul_b = (phase == PH_PROD) ? {16'd0, weight} : recip(lg);
  assign prod  = mul_a * mul_b;

  // quotient estimate is exact or one low; a remainder compare fixes it
  assign q0 = prod_r[31:24];
  assign qd = ({10'd0, q0} << bits) - {10'd0, q0};
  assign r0 = {2'd0, x} - qd;
  assign q  = q0 + {7'd0, (r0 >= {10'd0, maxl})};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      term  <= '0;
      phase <= PH_PROD;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        term  <= '0;
        phase <= PH_PROD;
      end else if (busy) begin
        case (phase)
          PH_PROD:  phase <= PH_RECIP;
          PH_RECIP: phase <= PH_FIX;
          default: begin
            phase <= PH_PROD;
            if (term == LAST_TERM) begin
              busy <= 1'b0;
              done <= 1'b1;
            end else begin
              term <= term + 3'd1;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      lg  <= req.pixel_bits_log2;
      lvl <= req.level;
      fg  <= req.fg;
      bg  <= req.bg;
      acc <= '0;
    end else if (busy) begin
      prod_r <= prod;
      if (phase == PH_RECIP) begin
        x <= prod_r[15:0];
      end
      if (phase == PH_FIX) begin
        acc[term[2:1]] <= acc[term[2:1]] + q;
      end
    end
  end

  assign resp.done  = done;
  assign resp.color = {acc[0], acc[1], acc[2]};

endmodule
